FILE: hw/rtl/mcwd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcwd_pkg: shared definitions for the microcode control word decoder
// Control line bits, register codes and payload types used by the interfaces
// and the decoder.
// ----------------------------------------------------------------------------
package mcwd_pkg;

  localparam int CwWidth  = 16;
  localparam int CodeBits = 5;
  localparam int CfgIdxW  = 1;

  // Control line bits, active-high view.
  localparam logic [15:0] K_CEM  = 16'h0001;
  localparam logic [15:0] K_LDO  = 16'h0002;
  localparam logic [15:0] K_LDS  = 16'h0004;
  localparam logic [15:0] K_LDRS = 16'h0008;
  localparam logic [15:0] K_LDIO = 16'h0010;
  localparam logic [15:0] K_Q    = 16'h0020;
  localparam logic [15:0] K_HLT  = 16'h0020;
  localparam logic [15:0] K_LDC  = 16'h0040;
  localparam logic [15:0] K_TG   = 16'h0080;
  localparam logic [15:0] K_WMEM = 16'h0100;
  localparam logic [15:0] K_WLS  = 16'h0200;
  localparam logic [15:0] K_WML  = 16'h0400;
  localparam logic [15:0] K_WMH  = 16'h0800;
  localparam logic [15:0] K_RML  = 16'h1000;
  localparam logic [15:0] K_RMH  = 16'h2000;
  localparam logic [15:0] K_RALU = 16'h4000;
  localparam logic [15:0] K_RMEM = 16'h8000;
  localparam logic [15:0] K_INV  = 16'hFF40;
  localparam logic [15:0] K_FETCH = K_RMEM | K_LDO | K_CEM;

  // Register and ALU codes.
  localparam logic [15:0] R_A  = 16'h0;
  localparam logic [15:0] R_B  = 16'h1;
  localparam logic [15:0] R_C  = 16'h2;
  localparam logic [15:0] R_SP = 16'h4;
  localparam logic [15:0] R_IL = 16'h5;
  localparam logic [15:0] R_JL = 16'h7;
  localparam logic [15:0] R_TL = 16'hB;
  localparam logic [15:0] R_TH = 16'hC;
  localparam logic [15:0] R_UL = 16'hD;
  localparam logic [15:0] ALU_DEC = 16'h4;

  // Configuration register indexes and reset values.
  localparam logic [CfgIdxW-1:0] CFG_ADD_BASE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IO_READ  = 1'b1;
  localparam logic [CodeBits-1:0] ADD_BASE_RST = 5'd6;
  localparam logic [CodeBits-1:0] IO_READ_RST  = 5'd10;

  typedef struct packed {
    logic [7:0] instr_byte;
    logic [3:0] micro_step;
    logic       flag_zero;
    logic       flag_carry;
    logic       flag_overflow;
    logic       flag_sign;
  } in_item_t;

  typedef struct packed {
    logic [CwWidth-1:0] control_word;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mcwd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcwd_in_if: input beat channel
// Valid/ready channel that carries one decode request per beat.
// ----------------------------------------------------------------------------
interface mcwd_in_if import mcwd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mcwd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcwd_out_if: result beat channel
// Valid/ready channel that carries one control word per beat.
// ----------------------------------------------------------------------------
interface mcwd_out_if import mcwd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mcwd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcwd_decode: control word lookup
// Combinational decode of opcode, step and flags into the pin-level word.
// ----------------------------------------------------------------------------
module mcwd_decode import mcwd_pkg::*; (
  input  wire in_item_t             item,
  input  wire logic [CodeBits-1:0] add_base,
  input  wire logic [CodeBits-1:0] io_read,
  output logic [CwWidth-1:0]        control_word
);

  logic [15:0] w;
  logic [15:0] r;
  logic [15:0] x;
  logic [7:0]  op;
  logic [3:0]  st;
  logic [7:0]  k;
  logic        f;
  logic        take;
  logic [CodeBits-1:0] bitop;

  assign op = item.instr_byte;
  assign st = item.micro_step;

  always_comb begin
    w     = K_HLT;
    r     = 16'h0;
    x     = 16'h0;
    k     = op - 8'h93;
    f     = 1'b0;
    take  = 1'b1;
    bitop = add_base + op[CodeBits-1:0] - 5'h10;
    case (op)
      8'h00: w = (st == 4'd7) ? K_LDS : ((st < 4'd7) ? 16'h0 : K_HLT);
      8'hFF: w = (st == 4'd2) ? K_LDS : K_HLT;
      8'h01, 8'h02, 8'h03, 8'h04, 8'hA0: begin
        r = (op == 8'hA0) ? R_SP : {8'h0, op - 8'h1};
        if (st == 4'd1) w = K_RMEM | K_WLS | K_Q | r | K_LDC | K_TG;
        else if (st == 4'd2) w = K_RALU | K_WMEM | K_TG | K_CEM | K_LDS;
      end
      8'h05, 8'h06: begin
        r = (op == 8'h05) ? R_IL : R_JL;
        case (st)
          4'd1: w = K_RMEM | K_WLS | K_Q | r | K_LDC | K_TG;
          4'd2: w = K_RALU | K_WMEM | K_TG | K_CEM;
          4'd3: w = K_RMEM | K_WLS | K_Q | (r + 16'h1) | K_LDC | K_TG;
          4'd4: w = K_RALU | K_WMEM | K_TG | K_CEM | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C: begin
        r = op[0] ? R_IL : R_JL;
        case (st)
          4'd1: w = R_TL | K_LDC | K_TG;
          4'd2: w = K_RML | K_WMEM | R_TH | K_LDC;
          4'd3: w = K_RMH | K_WMEM | r | K_LDC;
          4'd4: w = K_RMEM | K_WML | (r + 16'h1) | K_LDC;
          default: begin
            if (op <= 8'h08) begin
              case (st)
                4'd5: w = K_RMEM | K_WMH | K_TG;
                4'd6: w = K_RMEM | K_WLS | K_Q | R_A | K_LDC | K_TG;
                4'd7: w = K_RALU | K_WMEM | R_TL | K_LDC;
                4'd8: w = K_RMEM | K_WML | R_TH | K_LDC;
                4'd9: w = K_RMEM | K_WMH | K_TG | K_LDS;
                default: w = K_HLT;
              endcase
            end else if (op <= 8'h0A) begin
              case (st)
                4'd5: w = K_RMEM | K_WMH | K_TG;
                4'd6: w = K_RMEM | K_WLS | K_CEM | K_TG;
                4'd7: w = K_RMH | K_WMEM | r | K_LDC;
                4'd8: w = K_RML | K_WMEM | K_Q | R_A | K_LDC;
                4'd9: w = K_RALU | K_WMEM | R_TL | K_LDC;
                4'd10: w = K_RMEM | K_WML | R_TH | K_LDC;
                4'd11: w = K_RMEM | K_WMH | K_TG | K_LDS;
                default: w = K_HLT;
              endcase
            end else begin
              case (st)
                4'd5: w = K_RMEM | K_WMH | K_Q | R_A | K_LDC;
                4'd6: w = K_RMEM | K_WLS | K_TG;
                4'd7: w = K_RALU | K_WMEM | R_TL | K_LDC | K_TG;
                4'd8: w = K_RMEM | K_WML | R_TH | K_LDC;
                4'd9: w = K_RMEM | K_WMH | K_TG | K_LDS;
                default: w = K_HLT;
              endcase
            end
          end
        endcase
      end
      8'h0D, 8'h0E: begin
        r = (op == 8'h0D) ? R_IL : R_JL;
        case (st)
          4'd1: w = R_A | K_LDC | K_TG;
          4'd2: w = K_RMEM | K_WLS | R_TL | K_LDC;
          4'd3: w = K_RML | K_WMEM | R_TH | K_LDC;
          4'd4: w = K_RMH | K_WMEM | r | K_LDC;
          4'd5: w = K_RMEM | K_WML | K_Q | (r + 16'h1) | K_LDC;
          4'd6: w = K_RMEM | K_WMH | K_TG;
          4'd7: w = K_RALU | K_WMEM | K_CEM | K_TG;
          4'd8: w = K_RMH | K_WMEM | r | K_LDC;
          4'd9: w = K_RML | K_WMEM | R_TL | K_LDC;
          4'd10: w = K_RMEM | K_WML | R_TH | K_LDC;
          4'd11: w = K_RMEM | K_WMH | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'h21, 8'h22, 8'h23, 8'h24, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2B, 8'h2C, 8'h2D, 8'h2E: begin
        x = {11'h0, op[4:0]};
        case (st)
          4'd1: w = {14'h0, x[1:0]} | K_LDC | K_TG;
          4'd2: w = K_RMEM | K_WLS | K_Q | {13'h0, x[4:2]} | K_LDC;
          4'd3: w = K_RALU | K_WMEM | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h60, 8'h61: begin
        x = (op >= 8'h60) ? ALU_DEC : {13'h0, op[2:0]};
        r = (op == 8'h61) ? R_C : ((op == 8'h60) ? R_B : R_A);
        case (st)
          4'd1: w = r | K_LDC | K_TG;
          4'd2: w = K_RMEM | K_WLS | x | K_LDC;
          4'd3: w = K_RALU | K_WLS | K_Q | r | K_LDC;
          4'd4: w = K_RALU | K_WMEM | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'h50, 8'h51, 8'h52, 8'h53: begin
        case (st)
          4'd1: w = R_A | K_LDC | K_TG;
          4'd2: w = K_RMEM | K_WLS | R_B | K_LDC;
          4'd3: w = K_RMEM | K_LDRS;
          4'd4: w = {11'h0, bitop} | K_LDC;
          4'd5: w = K_RALU | K_WLS | K_Q | R_A | K_LDC;
          4'd6: w = K_RALU | K_WMEM | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'hB0: begin
        case (st)
          4'd1: w = K_RMEM | K_WLS | K_Q | R_TL | K_LDC | K_TG;
          4'd2: w = K_RALU | K_WMEM | K_TG | K_CEM;
          4'd3: w = K_RMEM | K_WLS | K_Q | R_TH | K_LDC | K_TG;
          4'd4: w = K_RALU | K_WMEM | K_CEM;
          4'd5: w = K_RML | K_WLS | R_UL | K_LDC;
          4'd6: w = K_RMH | K_WMEM | R_SP | K_LDC;
          4'd7: w = K_RMEM | K_WML | K_Q | R_UL | K_LDC;
          4'd8: w = K_WMH | K_CEM | K_TG;
          4'd9: w = K_RALU | K_WMEM | K_CEM | K_TG;
          4'd10: w = K_RMEM | K_WLS | K_TG;
          4'd11: w = K_RALU | K_WMEM | R_SP | K_LDC | K_TG;
          4'd12: w = K_RML | K_WMEM | R_TL | K_LDC;
          4'd13: w = K_RMEM | K_WML | R_TH | K_LDC;
          4'd14: w = K_RMEM | K_WMH | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'hB1: begin
        case (st)
          4'd1: w = R_SP | K_LDC | K_TG;
          4'd2: w = K_RMEM | K_WML | K_WLS;
          4'd3: w = K_RALU | K_WMEM;
          4'd4: w = K_WMH | K_TG;
          4'd5: w = K_RMEM | K_WLS | K_Q | R_TH | K_LDC | K_TG;
          4'd6: w = K_RALU | K_WMEM | R_SP | K_LDC;
          4'd7: w = K_RMEM | K_WML | K_WLS;
          4'd8: w = K_RALU | K_WMEM | K_TG;
          4'd9: w = K_RMEM | K_WML | R_TH | K_LDC | K_TG;
          4'd10: w = K_RMEM | K_WMH | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'hB2: begin
        case (st)
          4'd1: w = K_RMEM | K_LDRS | K_CEM;
          4'd2: w = R_TL | K_LDC | K_TG;
          4'd3: w = K_RML | K_WMEM | R_TH | K_LDC;
          4'd4: w = K_RMH | K_WMEM | R_SP | K_LDC;
          4'd5: w = K_RMEM | K_WLS | {11'h0, add_base} | K_LDC;
          4'd6: w = K_RALU | K_WML;
          4'd7: w = K_WMH | K_TG;
          4'd8: w = K_RMEM | K_WLS | K_Q | R_A | K_LDC | K_TG;
          4'd9: w = K_RALU | K_WMEM | R_TL | K_LDC;
          4'd10: w = K_RMEM | K_WML | R_TH | K_LDC;
          4'd11: w = K_RMEM | K_WMH | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'h90, 8'h91: begin
        r = (op == 8'h90) ? R_IL : R_JL;
        case (st)
          4'd1: w = r | K_LDC | K_TG;
          4'd2: w = K_RMEM | K_WML | (r + 16'h1) | K_LDC;
          4'd3: w = K_RMEM | K_WMH | K_LDS | K_TG;
          default: w = K_HLT;
        endcase
      end
      8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A: begin
        // Flag select from the condition pair, polarity from its low bit.
        case (k[2:1])
          2'd0: f = item.flag_zero;
          2'd1: f = item.flag_carry;
          2'd2: f = item.flag_overflow;
          default: f = item.flag_sign;
        endcase
        if (op != 8'h92) take = k[0] ? !f : f;
        case (st)
          4'd1: w = take ? (K_RMEM | K_WLS | K_CEM) : K_CEM;
          4'd2: w = take ? (K_RMEM | K_WMH | K_Q | K_LDC) : K_CEM;
          4'd3: w = take ? (K_RALU | K_WML | K_LDS) : K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'hA2, 8'hA3, 8'hA4, 8'hA5: begin
        case (st)
          4'd1: w = R_TL | K_LDC | K_TG;
          4'd2: w = K_RML | K_WMEM | R_TH | K_LDC;
          4'd3: w = K_RMH | K_WMEM | R_SP | K_LDC;
          4'd4: w = K_RMEM | K_WML;
          4'd5: w = K_WMH | K_CEM;
          4'd6: w = K_RML | K_WMEM | K_Q | {14'h0, op[1:0] - 2'd2} | K_LDC;
          4'd7: w = K_RMEM | K_WLS | K_TG;
          4'd8: w = K_RALU | K_WMEM | R_TL | K_LDC | K_TG;
          4'd9: w = K_RMEM | K_WML | R_TH | K_LDC;
          4'd10: w = K_RMEM | K_WMH | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'hA6, 8'hA7: begin
        r = (op == 8'hA6) ? R_IL : R_JL;
        case (st)
          4'd1: w = R_TL | K_LDC | K_TG;
          4'd2: w = K_RML | K_WMEM | R_TH | K_LDC;
          4'd3: w = K_RMH | K_WMEM | R_SP | K_LDC;
          4'd4: w = K_RMEM | K_WML | r | K_LDC;
          4'd5: w = K_WMH | K_CEM;
          4'd6: w = K_RMEM | K_WLS | K_Q | (r + 16'h1) | K_LDC | K_TG;
          4'd7: w = K_RALU | K_WMEM | K_CEM | K_TG;
          4'd8: w = K_RMEM | K_WLS | K_TG;
          4'd9: w = K_RALU | K_WMEM | R_SP | K_LDC | K_TG;
          4'd10: w = K_RML | K_WMEM | R_TL | K_LDC;
          4'd11: w = K_RMEM | K_WML | R_TH | K_LDC;
          4'd12: w = K_RMEM | K_WMH | K_TG | K_LDS;
          default: w = K_HLT;
        endcase
      end
      8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAD: begin
        r = (op == 8'hAC) ? R_IL : R_JL;
        case (st)
          4'd1: w = R_TL | K_LDC | K_TG;
          4'd2: w = K_RML | K_WMEM | R_TH | K_LDC;
          4'd3: w = K_RMH | K_WMEM | R_SP | K_LDC;
          4'd4: w = K_RMEM | K_WML | K_WLS;
          4'd5: w = K_RALU | K_WMEM;
          4'd6: w = K_WMH | K_TG;
          default: begin
            if (op <= 8'hAB) begin
              case (st)
                4'd7: w = K_RMEM | K_WLS | K_Q | {14'h0, op[1:0]} | K_LDC | K_TG;
                4'd8: w = K_RALU | K_WMEM | R_TL | K_LDC;
                4'd9: w = K_RMEM | K_WML | R_TH | K_LDC;
                4'd10: w = K_RMEM | K_WMH | K_TG | K_LDS;
                default: w = K_HLT;
              endcase
            end else begin
              case (st)
                4'd7: w = K_RMEM | K_WLS | K_Q | (r + 16'h1) | K_LDC | K_TG;
                4'd8: w = K_RALU | K_WMEM | R_SP | K_LDC;
                4'd9: w = K_RMEM | K_WML | K_WLS;
                4'd10: w = K_RALU | K_WMEM | K_TG;
                4'd11: w = K_RMEM | K_WLS | K_Q | r | K_LDC | K_TG;
                4'd12: w = K_RALU | K_WMEM | R_TL | K_LDC;
                4'd13: w = K_RMEM | K_WML | R_TH | K_LDC;
                4'd14: w = K_RMEM | K_WMH | K_TG | K_LDS;
                default: w = K_HLT;
              endcase
            end
          end
        endcase
      end
      default: begin
        // I/O groups by opcode range; anything else halts.
        if (op[7:3] == 5'b01111) begin
          if (st == 4'd1) w = K_RMEM | K_LDIO;
          else if (st == 4'd2) w = K_CEM | K_LDS;
        end else if (op[7:3] == 5'b10000) begin
          case (st)
            4'd1: w = {11'h0, io_read} | K_LDC | K_TG;
            4'd2: w = K_LDC;
            4'd3: w = K_WLS | K_Q | R_A | K_LDC;
            4'd4: w = K_RALU | K_WMEM | K_TG | K_LDS;
            default: w = K_HLT;
          endcase
        end else if (op[7:3] == 5'b10001) begin
          case (st)
            4'd1: w = R_A | K_LDC | K_TG;
            4'd2: w = K_RMEM | K_LDIO;
            4'd3: w = K_TG | K_LDS;
            default: w = K_HLT;
          endcase
        end
      end
    endcase
    if (st == 4'd0) w = K_FETCH;
  end

  assign control_word = w ^ K_INV;

endmodule
`default_nettype wire

FILE: hw/rtl/microcode_control_word_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// microcode_control_word_decoder_top: control word decoder
// Looks up the control word for a decode request and holds it in a
// result register until the sink takes it.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  in      | sink      | instr_byte, micro_step, four flags
//  out     | source    | control_word (pin level)
//  cfg     | write     | index 0 add base code, index 1 I/O read code
//
// One beat is taken per cycle unless stalled; a result appears next cycle.
// The single result register sets the latency; input is taken whenever that
// register is empty or being emptied in the same cycle.
// rst_n is synchronous; it empties the result register and restores config.
// A stalled sink holds the result and blocks input until it drains.
// ----------------------------------------------------------------------------
module microcode_control_word_decoder_top import mcwd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  mcwd_in_if.sink                     in_ch,
  mcwd_out_if.source                  out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CodeBits-1:0]   cfg_data
);

  logic [CodeBits-1:0] add_base_r;
  logic [CodeBits-1:0] io_read_r;
  logic                valid_r;
  logic [CwWidth-1:0]  word_r;
  logic [CwWidth-1:0]  word_nxt;
  logic                in_fire;

  // Input is taken when the result slot is free or draining.
  assign in_ch.ready = !valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_base_r <= ADD_BASE_RST;
      io_read_r  <= IO_READ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADD_BASE: add_base_r <= cfg_data;
        CFG_IO_READ:  io_read_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  mcwd_decode u_decode (
    .item         (in_ch.data),
    .add_base     (add_base_r),
    .io_read      (io_read_r),
    .control_word (word_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= word_nxt;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.data.control_word = word_r;

  // A stalled result must not change or vanish.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(word_r))
    else $error("result changed while stalled");

  // An accepted beat always shows up as a result next cycle.
  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> valid_r)
    else $error("accepted beat lost");

  // Input is refused only behind a stalled result.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> valid_r && !out_ch.ready)
    else $error("input stalled without cause");

endmodule
`default_nettype wire
